// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int PRIO_W   = 32;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry entry;
    } t_ctrl;

endpackage

// ===== rtl/spq_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready channels for operations in and results out.
// ----------------------------------------------------------------------------
interface spq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [spq_pkg::PRIO_W-1:0]  new_priority;
    logic [spq_pkg::DATA_W-1:0]  new_data;

    modport source (output valid, func, new_priority, new_data, input ready);
    modport sink   (input valid, func, new_priority, new_data, output ready);
endinterface

interface spq_out_if;
    logic                          valid;
    logic                          ready;
    logic                          head_valid;
    logic [spq_pkg::PRIO_W-1:0]    head_priority;
    logic [spq_pkg::DATA_W-1:0]    head_data;
    logic [spq_pkg::DATA_W-1:0]    removed_data;
    logic [spq_pkg::COUNT_W-1:0]   entry_count;
    logic [spq_pkg::STATUS_W-1:0]  status;

    modport source (output valid, head_valid, head_priority, head_data,
                    removed_data, entry_count, status, input ready);
    modport sink   (input valid, head_valid, head_priority, head_data,
                    removed_data, entry_count, status, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the queue: compares against the pushed entry and shifts
// towards the tail on push or towards the head on pop.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic            i_clk,
    input  spq_pkg::t_ctrl  i_ctrl,
    input  logic            i_head,
    input  logic            i_occupied,
    input  spq_pkg::t_entry i_left,
    input  logic            i_left_lt,
    input  spq_pkg::t_entry i_right,
    output spq_pkg::t_entry o_entry,
    output spq_pkg::t_entry o_next,
    output logic            o_lt
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            w_lt;

    // head keeps its place on equal priority, later slots do not
    always_comb begin
        if (i_head) begin
            w_lt = i_occupied && (r_entry.prio <= i_ctrl.entry.prio);
        end else begin
            w_lt = i_occupied && (r_entry.prio < i_ctrl.entry.prio);
        end
    end

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push && !w_lt) begin
            n_entry = i_left_lt ? i_ctrl.entry : i_left;
        end else if (i_ctrl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;
    assign o_lt    = w_lt;

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Bounded priority queue held as a sorted chain of slot cells.
// ----------------------------------------------------------------------------
// One push or pop is taken per clock cycle; its result is held in an
// output register, and a new operation is accepted while that
// result waits provided the result is taken in the same cycle. Every slot
// cell compares its entry with the pushed priority in parallel and moves
// towards the tail or head, so the rate does not depend on QUEUE_DEPTH.
// Slot contents are not cleared at reset; only slots below the fill count
// are ever read.
module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spq_in_if.sink       i_in,
    spq_out_if.source    o_out
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    spq_pkg::t_ctrl        w_ctrl;

    spq_pkg::t_entry       w_entry [QUEUE_DEPTH];
    spq_pkg::t_entry       w_next  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_lt;

    logic                          r_out_valid;
    logic                          r_head_valid;
    logic [spq_pkg::PRIO_W-1:0]    r_head_priority;
    logic [spq_pkg::DATA_W-1:0]    r_head_data;
    logic [spq_pkg::DATA_W-1:0]    r_removed_data;
    logic [spq_pkg::COUNT_W-1:0]   r_entry_count;
    logic [spq_pkg::STATUS_W-1:0]  r_status;
    logic [spq_pkg::STATUS_W-1:0]  n_status;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_ctrl.push       = w_accept && (i_in.func == spq_pkg::FUNC_PUSH) && !w_full;
        w_ctrl.pop        = w_accept && (i_in.func == spq_pkg::FUNC_POP) && !w_empty;
        w_ctrl.entry.prio = i_in.new_priority;
        w_ctrl.entry.data = i_in.new_data;
    end

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        if (w_ctrl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
        if (i_in.func == spq_pkg::FUNC_PUSH && w_full) begin
            n_status = spq_pkg::ST_FULL;
        end else if (i_in.func == spq_pkg::FUNC_POP && w_empty) begin
            n_status = spq_pkg::ST_POP_EMPTY;
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_left_lt;

        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_lt = 1'b1;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_head     (g == 0),
            .i_occupied (CNT_W'(g) < r_count),
            .i_left     (w_left),
            .i_left_lt  (w_left_lt),
            .i_right    (w_right),
            .o_entry    (w_entry[g]),
            .o_next     (w_next[g]),
            .o_lt       (w_lt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head_valid    <= (n_count != '0);
            r_head_priority <= (n_count != '0) ? w_next[0].prio : '0;
            r_head_data     <= (n_count != '0) ? w_next[0].data : '0;
            r_removed_data  <= w_ctrl.pop ? w_entry[0].data : '0;
            r_entry_count   <= spq_pkg::COUNT_W'(n_count);
            r_status        <= n_status;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.head_valid    = r_head_valid;
    assign o_out.head_priority = r_head_priority;
    assign o_out.head_data     = r_head_data;
    assign o_out.removed_data  = r_removed_data;
    assign o_out.entry_count   = r_entry_count;
    assign o_out.status        = r_status;

endmodule

// ===== bench/spq_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches the operation and result channels of the queue core. It keeps its
// own sorted copy of the queue to predict each result, then compares every
// result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module spq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_in_if    i_ops,
    spq_out_if   i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_pushes,
    output int   o_pops,
    output int   o_refused,
    output int   o_empty_pops
);

    typedef struct packed {
        logic                         head_valid;
        logic [spq_pkg::PRIO_W-1:0]   head_priority;
        logic [spq_pkg::DATA_W-1:0]   head_data;
        logic [spq_pkg::DATA_W-1:0]   removed_data;
        logic [spq_pkg::COUNT_W-1:0]  entry_count;
        logic [spq_pkg::STATUS_W-1:0] status;
    } t_outcome;

    logic [spq_pkg::PRIO_W-1:0] model_prio [QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0] model_data [QUEUE_DEPTH];
    int                         model_fill;
    t_outcome                   awaited_results [$];
    int                         mismatches;
    int                         pushes;
    int                         pops;
    int                         refused;
    int                         empty_pops;

    task automatic apply_op(input logic func, input logic [spq_pkg::PRIO_W-1:0] prio,
                            input logic [spq_pkg::DATA_W-1:0] data,
                            output t_outcome r);
        int pos;
        int k;
        r = '0;
        r.status = spq_pkg::ST_OK;
        if (func == spq_pkg::FUNC_PUSH) begin
            if (model_fill >= QUEUE_DEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                // equal priority never overtakes the head, but does overtake later ones
                if (model_fill == 0 || model_prio[0] > prio) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < model_fill && model_prio[pos] < prio) pos++;
                end
                for (k = model_fill; k > pos; k--) begin
                    model_prio[k] = model_prio[k-1];
                    model_data[k] = model_data[k-1];
                end
                model_prio[pos] = prio;
                model_data[pos] = data;
                model_fill++;
            end
        end else begin
            if (model_fill == 0) begin
                r.status = spq_pkg::ST_POP_EMPTY;
            end else begin
                r.removed_data = model_data[0];
                for (k = 1; k < model_fill; k++) begin
                    model_prio[k-1] = model_prio[k];
                    model_data[k-1] = model_data[k];
                end
                model_fill--;
            end
        end
        if (model_fill > 0) begin
            r.head_valid    = 1'b1;
            r.head_priority = model_prio[0];
            r.head_data     = model_data[0];
        end
        r.entry_count = model_fill[spq_pkg::COUNT_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        model_fill = 0;
        mismatches = 0;
        pushes     = 0;
        pops       = 0;
        refused    = 0;
        empty_pops = 0;
    end

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome next;
        if (!i_rst_n) begin
            model_fill = 0;
            awaited_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transaction with no operation outstanding");
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("head_valid", 32'(want.head_valid),
                                32'(i_res.head_valid));
                    check_field("head_priority", want.head_priority,
                                i_res.head_priority);
                    check_field("head_data", want.head_data, i_res.head_data);
                    check_field("removed_data", want.removed_data,
                                i_res.removed_data);
                    check_field("entry_count", 32'(want.entry_count),
                                32'(i_res.entry_count));
                    check_field("status", 32'(want.status), 32'(i_res.status));
                end
            end
            if (i_ops.valid && i_ops.ready) begin
                apply_op(i_ops.func, i_ops.new_priority, i_ops.new_data, next);
                awaited_results.push_back(next);
                if (i_ops.func == spq_pkg::FUNC_PUSH) pushes++;
                else pops++;
                if (next.status == spq_pkg::ST_FULL) refused++;
                if (next.status == spq_pkg::ST_POP_EMPTY) empty_pops++;
            end
        end
        o_errors     <= mismatches;
        o_pending    <= awaited_results.size();
        o_pushes     <= pushes;
        o_pops       <= pops;
        o_refused    <= refused;
        o_empty_pops <= empty_pops;
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives push and pop transactions into the queue core: a directed opening
// covering the empty, full and equal-priority cases, then random traffic in
// phases with different sender idling and receiver stalling. A checker beside
// the core predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PHASE_ITEMS  = 375;
    localparam int STALL_LIMIT  = 2000;

    logic i_clk;
    logic i_rst_n;

    int errors;
    int pending;
    int pushes;
    int pops;
    int refused;
    int empty_pops;
    int idle_pct;
    int stall_pct;

    spq_in_if  ops_ch ();
    spq_out_if res_ch ();

    sorted_priority_queue_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ops_ch),
        .o_out   (res_ch)
    );

    spq_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ops        (ops_ch),
        .i_res        (res_ch),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_pushes     (pushes),
        .o_pops       (pops),
        .o_refused    (refused),
        .o_empty_pops (empty_pops)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_op(input logic func, input logic [spq_pkg::PRIO_W-1:0] prio,
                           input logic [spq_pkg::DATA_W-1:0] data);
        while ($urandom_range(99) < idle_pct) begin
            ops_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        ops_ch.valid        <= 1'b1;
        ops_ch.func         <= func;
        ops_ch.new_priority <= prio;
        ops_ch.new_data     <= data;
        @(posedge i_clk);
        while (!ops_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain;
        ops_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // receiver
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (ops_ch.valid && ops_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("sorted_priority_queue_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int                         push_bias;
        logic [spq_pkg::PRIO_W-1:0] prio;
        idle_pct            = 0;
        stall_pct           = 0;
        i_rst_n            <= 1'b0;
        ops_ch.valid       <= 1'b0;
        ops_ch.func        <= spq_pkg::FUNC_PUSH;
        ops_ch.new_priority <= '0;
        ops_ch.new_data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening
        send_op(spq_pkg::FUNC_POP,  32'h1234_5678, 32'h9ABC_DEF0);
        send_op(spq_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_op(spq_pkg::FUNC_PUSH, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(spq_pkg::FUNC_PUSH, 32'h0000_0000, 32'hA5A5_A5A5);
        send_op(spq_pkg::FUNC_PUSH, 32'h0000_0005, 32'h5A5A_5A5A);
        send_op(spq_pkg::FUNC_PUSH, 32'h0000_0005, 32'h0F0F_0F0F);
        send_op(spq_pkg::FUNC_POP,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (12) send_op(spq_pkg::FUNC_PUSH, $urandom_range(15), $urandom());
        send_op(spq_pkg::FUNC_PUSH, 32'h0000_0000, 32'hDEAD_BEEF);
        send_op(spq_pkg::FUNC_POP,  32'h0000_0000, 32'h0000_0000);
        drain();

        // random phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            push_bias = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) push_bias = 15 + 35 * $urandom_range(2);
                case ($urandom_range(3))
                    0: prio = $urandom_range(7);
                    1: prio = $urandom();
                    2: prio = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                    default: prio = 32'hFFFF_FFF8 | $urandom_range(7);
                endcase
                send_op(($urandom_range(99) < push_bias) ? spq_pkg::FUNC_PUSH
                                                         : spq_pkg::FUNC_POP,
                        prio, $urandom());
            end
            drain();
        end

        ops_ch.valid <= 1'b0;
        repeat (8) @(posedge i_clk);
        $display("Ran %0d pushes and %0d pops through all idle/stall phases;", pushes, pops);
        $display("%0d pushes refused on a full queue, %0d pops on an empty one.",
                 refused, empty_pops);
        if (errors == 0 && pending == 0) begin
            $display("sorted_priority_queue_core: match");
        end else begin
            $display("sorted_priority_queue_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== sorted_priority_queue_core.f =====
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
bench/spq_checker.sv
bench/tb.sv
